[rtl/frti_pkg.sv]
// ----------------------------------------------------------------------------
// frti_pkg
// shared types and constants for the float round-to-integral unit
// ----------------------------------------------------------------------------
package frti_pkg;

	typedef enum logic [1:0] {
		MODE_ROUND = 2'd0,
		MODE_CEIL  = 2'd1,
		MODE_FIX   = 2'd2,
		MODE_FLOOR = 2'd3
	} mode_t;

	localparam int unsigned WORD_W = 64;

	// double precision format
	localparam int unsigned D_EW   = 11;
	localparam int unsigned D_FW   = 52;
	localparam logic [10:0] D_BIAS = 11'd1023;

	// single precision format
	localparam int unsigned S_EW   = 8;
	localparam int unsigned S_FW   = 23;
	localparam logic [7:0]  S_BIAS = 8'd127;

endpackage

[rtl/float_round_to_integral.sv]
// ----------------------------------------------------------------------------
// float_round_to_integral
// ieee 754 round to integral value, binary32 or binary64, four modes
// ----------------------------------------------------------------------------
// path: an accepted request passes the input register, then the result register,
//   and is valid once it sits in the result register
// throughput: one request per cycle while out_stall does not hold the result stage, set by the single rounding pass
// reset: arst_n clears the stage valid flags only; payload is not reset
module float_round_to_integral (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic        double_precision,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_bits
);
	import frti_pkg::*;

	// stage 1: input register
	logic        vld_s1;
	mode_t       mode_s1;
	logic        dbl_s1;
	logic [63:0] val_s1;

	// stage 2: result register
	logic        vld_s2;
	logic [63:0] res_s2;

	logic adv_s2;
	logic adv_s1;

	// the result stage moves when it is empty or being taken
	assign adv_s2    = !vld_s2 || !out_stall;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign in_stall  = !adv_s1;
	assign out_valid = vld_s2;
	assign result_bits = res_s2;

	// rounding of one format
	// d: full 64-bit word view; single precision uses the low 32 bits
	logic [63:0] dres;
	logic [31:0] sres;

	// double precision path
	always_comb begin
		logic        sg;
		logic [10:0] ex;
		logic [62:0] mag;
		logic [63:0] one_w;
		logic [63:0] fmask;
		logic [63:0] unit;
		logic [63:0] t;
		logic [5:0]  m;
		sg    = val_s1[63];
		ex    = val_s1[62:52];
		mag   = val_s1[62:0];
		one_w = {1'b0, D_BIAS, 52'd0};
		m     = 6'(11'(D_BIAS) + 11'(D_FW) - ex);
		unit  = 64'd1 << m;
		fmask = unit - 64'd1;
		t     = val_s1 & ~fmask;
		dres  = val_s1;
		if (ex == 11'h7ff || mag == 63'd0 || ex >= 11'(D_BIAS + 11'(D_FW))) begin
			dres = val_s1;
		end else if (ex < D_BIAS) begin
			// magnitude below one
			case (mode_s1)
				MODE_ROUND: dres = (ex == D_BIAS - 11'd1) ? ({sg, 63'd0} | one_w)
					: {sg, 63'd0};
				MODE_CEIL:  dres = sg ? {sg, 63'd0} : one_w;
				MODE_FIX:   dres = {sg, 63'd0};
				default:    dres = sg ? ({sg, 63'd0} | one_w) : 64'd0;
			endcase
		end else if ((val_s1 & fmask) != 64'd0) begin
			case (mode_s1)
				MODE_ROUND: dres = ((val_s1 & (unit >> 1)) != 64'd0) ? t + unit : t;
				MODE_CEIL:  dres = sg ? t : t + unit;
				MODE_FIX:   dres = t;
				default:    dres = sg ? t + unit : t;
			endcase
		end
	end

	// single precision path
	always_comb begin
		logic        sg;
		logic [7:0]  ex;
		logic [30:0] mag;
		logic [31:0] x;
		logic [31:0] one_w;
		logic [31:0] fmask;
		logic [31:0] unit;
		logic [31:0] t;
		logic [4:0]  m;
		x     = val_s1[31:0];
		sg    = x[31];
		ex    = x[30:23];
		mag   = x[30:0];
		one_w = {1'b0, S_BIAS, 23'd0};
		m     = 5'(8'(S_BIAS) + 8'(S_FW) - ex);
		unit  = 32'd1 << m;
		fmask = unit - 32'd1;
		t     = x & ~fmask;
		sres  = x;
		if (ex == 8'hff || mag == 31'd0 || ex >= 8'(S_BIAS + 8'(S_FW))) begin
			sres = x;
		end else if (ex < S_BIAS) begin
			case (mode_s1)
				MODE_ROUND: sres = (ex == S_BIAS - 8'd1) ? ({sg, 31'd0} | one_w)
					: {sg, 31'd0};
				MODE_CEIL:  sres = sg ? {sg, 31'd0} : one_w;
				MODE_FIX:   sres = {sg, 31'd0};
				default:    sres = sg ? ({sg, 31'd0} | one_w) : 32'd0;
			endcase
		end else if ((x & fmask) != 32'd0) begin
			case (mode_s1)
				MODE_ROUND: sres = ((x & (unit >> 1)) != 32'd0) ? t + unit : t;
				MODE_CEIL:  sres = sg ? t : t + unit;
				MODE_FIX:   sres = t;
				default:    sres = sg ? t + unit : t;
			endcase
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			mode_s1 <= mode_t'(mode);
			dbl_s1  <= double_precision;
			val_s1  <= value_bits;
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= dbl_s1 ? dres : {32'd0, sres};
		end
	end

endmodule

[rtl/frti_checker.sv]
// ----------------------------------------------------------------------------
// frti_checker
// port-level checks for the round-to-integral unit, bound to the top level
// ----------------------------------------------------------------------------
module frti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result_bits
);
	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_bits))
		else $error("held result changed");

	// input is never stalled while the output side is free
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled with free output");

	// an accepted request reaches out_valid unless out_stall holds
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall |=> out_valid)
		else $error("result missing");

	// no result appears without an earlier request
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid, 2) || $past(in_valid, 1) || $past(in_stall))
		else $error("unexpected result");

endmodule

bind float_round_to_integral frti_checker u_frti_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .result_bits(result_bits)
);
